[src/rfc_pkg.sv]
// ----------------------------------------------------------------------------
// rfc_pkg
// Shared types and constants for the reader frame checker and ID table.
// ----------------------------------------------------------------------------
package rfc_pkg;

    localparam logic [7:0] BYTE_START = 8'h02;
    localparam logic [7:0] BYTE_END   = 8'h03;

    // characters 0..9 carry the data pairs, 10..11 the check pair
    localparam int HEX_CHARS = 12;
    localparam int CHECK_POS = 10;

    typedef enum logic [1:0] {
        MODE_NONE  = 2'd0,
        MODE_DEREG = 2'd1,
        MODE_CHECK = 2'd2,
        MODE_REG   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        O_NOTHING = 2'd0,
        O_SUCCESS = 2'd1,
        O_FAILURE = 2'd2
    } t_outcome;

    typedef enum logic [2:0] {
        R_NONE      = 3'd0,
        R_DONE      = 3'd1,
        R_BAD_CSUM  = 3'd2,
        R_FULL      = 3'd3,
        R_DUP       = 3'd4,
        R_NOT_FOUND = 3'd5,
        R_EMPTY     = 3'd6,
        R_NO_MODE   = 3'd7
    } t_reason;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHK,
        ST_LOOK,
        ST_INS,
        ST_SHIFT
    } t_state;

    typedef struct packed {
        logic start;
        logic step;
        logic odd;
        logic is_check;
    } t_xsum_ctl;

    typedef struct packed {
        logic good;
    } t_xsum_sts;

endpackage

[src/rfc_ifs.sv]
// ----------------------------------------------------------------------------
// rfc_ifs
// Valid/ready channels for reader bytes and frame results.
// ----------------------------------------------------------------------------
interface rfc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rfc_result_if;
    logic       valid;
    logic       ready;
    logic       frame_done;
    logic [1:0] outcome;
    logic [2:0] reason;
    logic [2:0] entry_count;

    modport source (output valid, output frame_done, output outcome, output reason,
                    output entry_count, input ready);
    modport sink   (input valid, input frame_done, input outcome, input reason,
                    input entry_count, output ready);
endinterface

[src/rfc_xsum.sv]
// ----------------------------------------------------------------------------
// rfc_xsum
// Shared hex decoder and XOR accumulator, one frame character per step.
// ----------------------------------------------------------------------------
module rfc_xsum (
    input  logic                i_clk,
    input  rfc_pkg::t_xsum_ctl  i_ctl,
    input  logic [7:0]          i_char,
    output rfc_pkg::t_xsum_sts  o_sts
);
    import rfc_pkg::*;

    logic [3:0] r_hi;
    logic [7:0] r_sum;
    logic       r_bad;

    logic       hex_ok;
    logic [3:0] hex_nib;
    logic [7:0] pair;
    logic [7:0] diff_lc;
    logic [7:0] diff_uc;

    always_comb begin
        diff_lc = i_char - 8'h57;
        diff_uc = i_char - 8'h37;
        hex_ok  = 1'b1;
        hex_nib = i_char[3:0];
        if (i_char >= 8'h61 && i_char <= 8'h66) begin
            hex_nib = diff_lc[3:0];
        end else if (i_char >= 8'h41 && i_char <= 8'h46) begin
            hex_nib = diff_uc[3:0];
        end else if (i_char >= 8'h30 && i_char <= 8'h39) begin
            hex_nib = i_char[3:0];
        end else begin
            hex_ok = 1'b0;
        end
    end

    assign pair = {r_hi, hex_nib};

    // valid on the step that presents the last check character
    assign o_sts.good = !r_bad && hex_ok && (r_sum == pair) && (r_sum != 8'h00);

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_sum <= '0;
            r_bad <= 1'b0;
        end else if (i_ctl.step) begin
            if (!hex_ok) begin
                r_bad <= 1'b1;
            end
            if (!i_ctl.odd) begin
                r_hi <= hex_nib;
            end else if (!i_ctl.is_check) begin
                r_sum <= r_sum ^ pair;
            end
        end
    end

endmodule

[src/rfc_id_mem.sv]
// ----------------------------------------------------------------------------
// rfc_id_mem
// ID table storage, one byte per word, registered read.
// ----------------------------------------------------------------------------
module rfc_id_mem #(
    parameter int AW = 7
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);
    logic [7:0] r_mem [2**AW];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

[src/rfid_frame_check_and_id_table_core.sv]
// ----------------------------------------------------------------------------
// rfid_frame_check_and_id_table_core
// Reader frame checker with XOR checksum and a small ID table.
// ----------------------------------------------------------------------------
// Bytes are taken one request at a time. A start or data byte is answered in
// the next cycle. An end byte runs a checksum pass through the shared hex
// decoder, then works on the ID table through its single read and single write
// port, one byte per cycle: a lookup reads the stored entries in slot order
// until a match or the last entry, an insert writes the ID after the stored
// entries, and a removal moves later entries up one slot, or none when the
// last entry is removed. The byte channel stays not ready while an end byte is
// being worked on and while a result waits to be taken. The table needs no
// clearing after reset: only slots below the stored count are ever read.
module rfid_frame_check_and_id_table_core #(
    parameter int TABLE_ENTRIES   = 5,
    parameter int ID_BUFFER_BYTES = 15
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_wdata,
    rfc_byte_if.sink      i_rx,
    rfc_result_if.source  o_res
);
    import rfc_pkg::*;

    localparam int FM   = ID_BUFFER_BYTES - 1;
    localparam int CW   = $clog2(FM);
    localparam int LW   = $clog2(FM + 1);
    localparam int CNTW = $clog2(TABLE_ENTRIES + 1);
    localparam int SW   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int AW   = SW + CW;

    localparam logic [CW-1:0]   CHK_LAST = CW'(HEX_CHARS - 1);
    localparam logic [CW-1:0]   CHK_POS  = CW'(CHECK_POS);
    localparam logic [CW-1:0]   FM_LAST  = CW'(FM - 1);
    localparam logic [LW-1:0]   FM_LEN   = LW'(FM);
    localparam logic [CNTW-1:0] TE_CNT   = CNTW'(TABLE_ENTRIES);

    t_state          r_state, n_state;
    t_mode           r_lock_mode;
    logic [CW-1:0]   r_c, n_c;
    logic [CNTW-1:0] r_slot, n_slot;
    logic [CNTW-1:0] r_count, n_count;
    logic            r_pv, n_pv;
    logic [CNTW-1:0] r_ps, n_ps;
    logic [CW-1:0]   r_pc, n_pc;
    logic            r_mis, n_mis;
    logic [7:0]      r_chars [FM];
    logic [7:0]      n_chars [FM];
    logic [LW-1:0]   r_len, n_len;
    logic            r_zero, n_zero;

    logic            r_ov, n_ov;
    logic            r_done, n_done;
    t_outcome        r_outcome, n_outcome;
    t_reason         r_reason, n_reason;
    logic [2:0]      r_res_count, n_res_count;

    logic            rx_ready;
    logic            rx_accept;
    logic            res_take;
    logic [CW-1:0]   sel_idx;
    logic [7:0]      sel_char;
    logic [CNTW-1:0] slot_inc;
    logic            look_issue;
    logic            shift_issue;

    t_xsum_ctl       xs_ctl;
    t_xsum_sts       xs_sts;

    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [7:0]      mem_wdata;
    logic            mem_re;
    logic [AW-1:0]   mem_raddr;
    logic [7:0]      mem_q;

    assign rx_accept   = i_rx.valid && rx_ready;
    assign res_take    = r_ov && o_res.ready;
    assign sel_char    = r_chars[sel_idx];
    assign slot_inc    = r_slot + CNTW'(1);
    assign look_issue  = r_slot < r_count;
    assign shift_issue = slot_inc < r_count;

    rfc_xsum u_xsum (
        .i_clk  (i_clk),
        .i_ctl  (xs_ctl),
        .i_char (sel_char),
        .o_sts  (xs_sts)
    );

    rfc_id_mem #(
        .AW (AW)
    ) u_id_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_q)
    );

    // next state and datapath
    always_comb begin
        logic fin;
        logic load;
        logic start_look;
        logic hit;
        logic miss;
        logic mis_now;

        n_state     = r_state;
        n_c         = r_c;
        n_slot      = r_slot;
        n_count     = r_count;
        n_pv        = r_pv;
        n_ps        = r_ps;
        n_pc        = r_pc;
        n_mis       = r_mis;
        n_chars     = r_chars;
        n_len       = r_len;
        n_zero      = r_zero;
        n_ov        = r_ov;
        n_done      = r_done;
        n_outcome   = r_outcome;
        n_reason    = r_reason;
        n_res_count = r_res_count;
        fin         = 1'b0;
        load        = 1'b0;
        start_look  = 1'b0;
        hit         = 1'b0;
        miss        = 1'b0;
        mis_now     = 1'b0;

        if (res_take) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (rx_accept) begin
                    if (i_rx.rx_byte == BYTE_START) begin
                        n_chars   = '{default: '0};
                        n_len     = '0;
                        n_zero    = 1'b0;
                        load      = 1'b1;
                        n_done    = 1'b0;
                        n_outcome = O_NOTHING;
                        n_reason  = R_NONE;
                    end else if (i_rx.rx_byte != BYTE_END) begin
                        // bytes after a zero are stored as zero, so the buffer
                        // already holds the ID as it is compared and stored
                        if (r_len < FM_LEN) begin
                            n_chars[r_len[CW-1:0]] = r_zero ? 8'h00 : i_rx.rx_byte;
                            n_len = r_len + LW'(1);
                            if (i_rx.rx_byte == 8'h00) begin
                                n_zero = 1'b1;
                            end
                        end
                        load      = 1'b1;
                        n_done    = 1'b0;
                        n_outcome = O_NOTHING;
                        n_reason  = R_NONE;
                    end else begin
                        n_state = ST_CHK;
                        n_c     = '0;
                    end
                end
            end
            ST_CHK: begin
                n_c = r_c + CW'(1);
                if (r_c == CHK_LAST) begin
                    if (!xs_sts.good) begin
                        fin       = 1'b1;
                        n_outcome = O_FAILURE;
                        n_reason  = R_BAD_CSUM;
                    end else begin
                        unique case (r_lock_mode)
                            MODE_REG: begin
                                if (r_count >= TE_CNT) begin
                                    fin       = 1'b1;
                                    n_outcome = O_FAILURE;
                                    n_reason  = R_FULL;
                                end else if (r_count == '0) begin
                                    n_state = ST_INS;
                                    n_c     = '0;
                                end else begin
                                    start_look = 1'b1;
                                end
                            end
                            MODE_DEREG: begin
                                if (r_count == '0) begin
                                    fin       = 1'b1;
                                    n_outcome = O_FAILURE;
                                    n_reason  = R_EMPTY;
                                end else begin
                                    start_look = 1'b1;
                                end
                            end
                            MODE_CHECK: begin
                                if (r_count == '0) begin
                                    fin       = 1'b1;
                                    n_outcome = O_FAILURE;
                                    n_reason  = R_NOT_FOUND;
                                end else begin
                                    start_look = 1'b1;
                                end
                            end
                            MODE_NONE: begin
                                fin       = 1'b1;
                                n_outcome = O_NOTHING;
                                n_reason  = R_NO_MODE;
                            end
                            default: begin
                                fin       = 1'b1;
                                n_outcome = O_NOTHING;
                                n_reason  = R_NO_MODE;
                            end
                        endcase
                    end
                end
                if (start_look) begin
                    n_state = ST_LOOK;
                    n_c     = '0;
                    n_slot  = '0;
                    n_pv    = 1'b0;
                    n_mis   = 1'b0;
                end
            end
            ST_LOOK: begin
                // read issue
                if (look_issue) begin
                    n_pv = 1'b1;
                    n_ps = r_slot;
                    n_pc = r_c;
                    if (r_c == FM_LAST) begin
                        n_c    = '0;
                        n_slot = slot_inc;
                    end else begin
                        n_c = r_c + CW'(1);
                    end
                end else begin
                    n_pv = 1'b0;
                end
                // compare of the byte read in the previous cycle
                if (r_pv) begin
                    mis_now = r_mis | (mem_q != sel_char);
                    n_mis   = mis_now;
                    if (r_pc == FM_LAST) begin
                        n_mis = 1'b0;
                        if (!mis_now) begin
                            hit = 1'b1;
                        end else if (r_ps == r_count - CNTW'(1)) begin
                            miss = 1'b1;
                        end
                    end
                end
                if (hit || miss) begin
                    unique case (r_lock_mode)
                        MODE_REG: begin
                            if (hit) begin
                                fin       = 1'b1;
                                n_outcome = O_FAILURE;
                                n_reason  = R_DUP;
                            end else begin
                                n_state = ST_INS;
                                n_c     = '0;
                            end
                        end
                        MODE_DEREG: begin
                            if (miss) begin
                                fin       = 1'b1;
                                n_outcome = O_FAILURE;
                                n_reason  = R_NOT_FOUND;
                            end else begin
                                n_state = ST_SHIFT;
                                n_slot  = r_ps;
                                n_c     = '0;
                                n_pv    = 1'b0;
                            end
                        end
                        MODE_CHECK: begin
                            fin       = 1'b1;
                            n_outcome = hit ? O_SUCCESS : O_FAILURE;
                            n_reason  = hit ? R_DONE : R_NOT_FOUND;
                        end
                        MODE_NONE: begin
                            fin       = 1'b1;
                            n_outcome = O_NOTHING;
                            n_reason  = R_NO_MODE;
                        end
                        default: begin
                            fin       = 1'b1;
                            n_outcome = O_NOTHING;
                            n_reason  = R_NO_MODE;
                        end
                    endcase
                end
            end
            ST_INS: begin
                n_c = r_c + CW'(1);
                if (r_c == FM_LAST) begin
                    n_count   = r_count + CNTW'(1);
                    fin       = 1'b1;
                    n_outcome = O_SUCCESS;
                    n_reason  = R_DONE;
                end
            end
            ST_SHIFT: begin
                // move slot+1 into slot, byte by byte, each write in the cycle after its read
                if (shift_issue) begin
                    n_pv = 1'b1;
                    n_ps = r_slot;
                    n_pc = r_c;
                    if (r_c == FM_LAST) begin
                        n_c    = '0;
                        n_slot = slot_inc;
                    end else begin
                        n_c = r_c + CW'(1);
                    end
                end else begin
                    n_pv = 1'b0;
                    if (!r_pv) begin
                        n_count   = r_count - CNTW'(1);
                        fin       = 1'b1;
                        n_outcome = O_SUCCESS;
                        n_reason  = R_DONE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (fin) begin
            load    = 1'b1;
            n_done  = 1'b1;
            n_chars = '{default: '0};
            n_len   = '0;
            n_zero  = 1'b0;
            n_state = ST_IDLE;
        end
        if (load) begin
            n_ov        = 1'b1;
            n_res_count = 3'(n_count);
        end
    end

    // control outputs
    always_comb begin
        rx_ready        = 1'b0;
        xs_ctl.start    = 1'b0;
        xs_ctl.step     = 1'b0;
        xs_ctl.odd      = r_c[0];
        xs_ctl.is_check = r_c >= CHK_POS;
        sel_idx         = r_c;
        mem_re          = 1'b0;
        mem_raddr       = {r_slot[SW-1:0], r_c};
        mem_we          = 1'b0;
        mem_waddr       = {r_ps[SW-1:0], r_pc};
        mem_wdata       = mem_q;

        unique case (r_state)
            ST_IDLE: begin
                rx_ready     = !r_ov || o_res.ready;
                xs_ctl.start = rx_accept && (i_rx.rx_byte == BYTE_END);
            end
            ST_CHK: begin
                xs_ctl.step = 1'b1;
            end
            ST_LOOK: begin
                sel_idx   = r_pc;
                mem_re    = look_issue;
                mem_raddr = {r_slot[SW-1:0], r_c};
            end
            ST_INS: begin
                mem_we    = 1'b1;
                mem_waddr = {r_count[SW-1:0], r_c};
                mem_wdata = sel_char;
            end
            ST_SHIFT: begin
                mem_re    = shift_issue;
                mem_raddr = {slot_inc[SW-1:0], r_c};
                mem_we    = r_pv;
                mem_waddr = {r_ps[SW-1:0], r_pc};
                mem_wdata = mem_q;
            end
            default: begin
                rx_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_lock_mode <= MODE_NONE;
            r_count     <= '0;
            r_pv        <= 1'b0;
            r_chars     <= '{default: '0};
            r_len       <= '0;
            r_zero      <= 1'b0;
            r_ov        <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_lock_mode <= t_mode'(i_cfg_wdata);
            end
            r_count <= n_count;
            r_pv    <= n_pv;
            r_chars <= n_chars;
            r_len   <= n_len;
            r_zero  <= n_zero;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c         <= n_c;
        r_slot      <= n_slot;
        r_ps        <= n_ps;
        r_pc        <= n_pc;
        r_mis       <= n_mis;
        r_done      <= n_done;
        r_outcome   <= n_outcome;
        r_reason    <= n_reason;
        r_res_count <= n_res_count;
    end

    assign i_rx.ready        = rx_ready;
    assign o_res.valid       = r_ov;
    assign o_res.frame_done  = r_done;
    assign o_res.outcome     = r_outcome;
    assign o_res.reason      = r_reason;
    assign o_res.entry_count = r_res_count;

endmodule

[verif/rfc_result_checker.sv]
// ----------------------------------------------------------------------------
// rfc_result_checker
// Watches the reader byte and result channels of the frame checker, predicts
// the result of every accepted byte and compares it field by field.
// ----------------------------------------------------------------------------
module rfc_result_checker #(
    parameter int TABLE_ENTRIES   = 5,
    parameter int ID_BUFFER_BYTES = 15
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_wdata,
    input  logic       i_rx_valid,
    input  logic       i_rx_ready,
    input  logic [7:0] i_rx_byte,
    input  logic       i_res_valid,
    input  logic       i_res_ready,
    input  logic       i_res_frame_done,
    input  logic [1:0] i_res_outcome,
    input  logic [2:0] i_res_reason,
    input  logic [2:0] i_res_entry_count,
    output int         o_fail_count,
    output int         o_results_owed
);
    timeunit 1ns;
    timeprecision 1ps;
    import rfc_pkg::*;

    localparam int FRAME_MAX = ID_BUFFER_BYTES - 1;

    typedef logic [FRAME_MAX-1:0][7:0] t_id;

    typedef struct packed {
        logic       frame_done;
        t_outcome   outcome;
        t_reason    reason;
        logic [2:0] entry_count;
    } t_frame_result;

    t_id           frame_buf;
    int            frame_fill;
    t_id           id_slots [TABLE_ENTRIES];
    int            id_total;
    t_mode         lock_mode_q;
    t_frame_result results_due [$];
    int            fail_total = 0;

    function automatic int hex_nibble(logic [7:0] c);
        if (c >= "a" && c <= "f") return int'(c - "a") + 10;
        if (c >= "A" && c <= "F") return int'(c - "A") + 10;
        if (c >= "0" && c <= "9") return int'(c - "0");
        return -1;
    endfunction

    function automatic int hex_pair_at(int pos);
        int hi;
        int lo;
        if (pos + 1 >= FRAME_MAX) return -1;
        hi = hex_nibble(frame_buf[pos]);
        lo = hex_nibble(frame_buf[pos + 1]);
        if (hi < 0 || lo < 0) return -1;
        return hi * 16 + lo;
    endfunction

    function automatic int find_id(t_id id);
        for (int k = 0; k < id_total && k < TABLE_ENTRIES; k++) begin
            if (id_slots[k] == id) return k;
        end
        return -1;
    endfunction

    // advances the frame buffer and ID table by one reader byte
    function automatic t_frame_result apply_reader_byte(logic [7:0] b);
        t_frame_result r;
        int            chk;
        int            v;
        int            idx;
        int            k;
        logic [7:0]    sum;
        logic          ok;
        logic          seen_zero;
        t_id           id;
        r.frame_done = 1'b0;
        r.outcome    = O_NOTHING;
        r.reason     = R_NONE;
        if (b == BYTE_START) begin
            frame_buf  = '0;
            frame_fill = 0;
        end else if (b != BYTE_END) begin
            if (frame_fill < FRAME_MAX) begin
                frame_buf[frame_fill] = b;
                frame_fill++;
            end
        end else begin
            chk = hex_pair_at(CHECK_POS);
            ok  = (chk >= 0);
            sum = '0;
            for (k = 0; k < CHECK_POS && ok; k += 2) begin
                v = hex_pair_at(k);
                if (v < 0) ok = 1'b0;
                else sum ^= v[7:0];
            end
            r.frame_done = 1'b1;
            if (!ok || sum != chk[7:0] || sum == 8'h00) begin
                r.outcome = O_FAILURE;
                r.reason  = R_BAD_CSUM;
            end else begin
                // the id stops at the first zero character
                seen_zero = 1'b0;
                for (k = 0; k < FRAME_MAX; k++) begin
                    if (frame_buf[k] == 8'h00) seen_zero = 1'b1;
                    id[k] = seen_zero ? 8'h00 : frame_buf[k];
                end
                idx = find_id(id);
                case (lock_mode_q)
                    MODE_REG: begin
                        if (id_total >= TABLE_ENTRIES) begin
                            r.outcome = O_FAILURE;
                            r.reason  = R_FULL;
                        end else if (idx >= 0) begin
                            r.outcome = O_FAILURE;
                            r.reason  = R_DUP;
                        end else begin
                            id_slots[id_total] = id;
                            id_total++;
                            r.outcome = O_SUCCESS;
                            r.reason  = R_DONE;
                        end
                    end
                    MODE_DEREG: begin
                        if (id_total == 0) begin
                            r.outcome = O_FAILURE;
                            r.reason  = R_EMPTY;
                        end else if (idx < 0) begin
                            r.outcome = O_FAILURE;
                            r.reason  = R_NOT_FOUND;
                        end else begin
                            id_total--;
                            // close the gap, clear the freed slot
                            for (k = idx; k < id_total; k++) id_slots[k] = id_slots[k + 1];
                            id_slots[id_total] = '0;
                            r.outcome = O_SUCCESS;
                            r.reason  = R_DONE;
                        end
                    end
                    MODE_CHECK: begin
                        r.outcome = (idx >= 0) ? O_SUCCESS : O_FAILURE;
                        r.reason  = (idx >= 0) ? R_DONE : R_NOT_FOUND;
                    end
                    default: begin
                        r.outcome = O_NOTHING;
                        r.reason  = R_NO_MODE;
                    end
                endcase
            end
            frame_buf  = '0;
            frame_fill = 0;
        end
        r.entry_count = id_total[2:0];
        return r;
    endfunction

    task automatic report_field(string field, int expd, int act);
        if (expd != act) begin
            $display("%0t: %s expected %0d actual %0d", $time, field, expd, act);
            fail_total++;
        end
    endtask

    always @(posedge i_clk) begin
        t_frame_result due;
        if (!i_rst_n) begin
            frame_buf  = '0;
            frame_fill = 0;
            foreach (id_slots[k]) id_slots[k] = '0;
            id_total    = 0;
            lock_mode_q = MODE_NONE;
            results_due.delete();
        end else begin
            if (i_cfg_we) lock_mode_q = t_mode'(i_cfg_wdata);
            if (i_res_valid && i_res_ready) begin
                if (results_due.size() == 0) begin
                    $display("%0t: result expected none actual done %0d outcome %0d %s",
                             $time, i_res_frame_done, i_res_outcome,
                             $sformatf("reason %0d count %0d", i_res_reason,
                                       i_res_entry_count));
                    fail_total++;
                end else begin
                    due = results_due.pop_front();
                    report_field("frame_done", due.frame_done, i_res_frame_done);
                    report_field("outcome", due.outcome, i_res_outcome);
                    report_field("reason", due.reason, i_res_reason);
                    report_field("entry_count", due.entry_count, i_res_entry_count);
                end
            end
            if (i_rx_valid && i_rx_ready) results_due.push_back(apply_reader_byte(i_rx_byte));
        end
        o_fail_count   <= fail_total;
        o_results_owed <= results_due.size();
    end

endmodule

[verif/tb_rfid_frame_check_and_id_table_core.sv]
// ----------------------------------------------------------------------------
// tb_rfid_frame_check_and_id_table_core
// Drives reader byte streams into the frame checker: a few directed bytes and
// frames, then random frames built around a small pool of tag IDs, through
// register, deregister, check and no-action modes under varying idle and stall.
// ----------------------------------------------------------------------------
module tb_rfid_frame_check_and_id_table_core;
    timeunit 1ns;
    timeprecision 1ps;
    import rfc_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 6;
    localparam int LIMIT_CYCLES  = 1000000;
    localparam int PHASES        = 4;
    localparam int SEGMENTS      = 4;
    localparam int SEGMENT_ITEMS = 120;
    localparam int POOL_SIZE     = 7;
    localparam int MAX_CHARS     = 20;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 150;

    typedef logic [MAX_CHARS-1:0][7:0] t_chars;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    logic [1:0] cfg_wdata;
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    int         cycle_count    = 0;
    int         items_sent     = 0;
    int         fail_count;
    int         results_owed;
    t_chars     pool_chars [POOL_SIZE];
    int         pool_len [POOL_SIZE];
    logic [7:0] frame_bytes [$];

    rfc_byte_if   u_rx_if ();
    rfc_result_if u_res_if ();

    rfid_frame_check_and_id_table_core u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_rx        (u_rx_if),
        .o_res       (u_res_if)
    );

    rfc_result_checker u_checker (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_wdata       (cfg_wdata),
        .i_rx_valid        (u_rx_if.valid),
        .i_rx_ready        (u_rx_if.ready),
        .i_rx_byte         (u_rx_if.rx_byte),
        .i_res_valid       (u_res_if.valid),
        .i_res_ready       (u_res_if.ready),
        .i_res_frame_done  (u_res_if.frame_done),
        .i_res_outcome     (u_res_if.outcome),
        .i_res_reason      (u_res_if.reason),
        .i_res_entry_count (u_res_if.entry_count),
        .o_fail_count      (fail_count),
        .o_results_owed    (results_owed)
    );

    always #CLK_HALF clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("rfid_frame_check_and_id_table_core test failed");
            $finish;
        end
    end

    always @(posedge clk) begin
        u_res_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    function automatic logic [7:0] hex_char(logic [3:0] nib);
        if (nib < 4'd10) return 8'("0" + nib);
        return 8'(($urandom_range(0, 1) ? "A" : "a") + nib - 4'd10);
    endfunction

    // trailing characters: hex, zero (which ends the id) or printable
    function automatic logic [7:0] extra_char();
        case ($urandom_range(0, 3))
            0:       return hex_char(4'($urandom_range(0, 15)));
            1:       return 8'h00;
            default: return 8'($urandom_range(8'h20, 8'h7e));
        endcase
    endfunction

    task automatic build_chars(input bit zero_sum, output t_chars c, output int n);
        logic [7:0] d;
        logic [7:0] sum;
        int         k;
        c = '0;
        do begin
            sum = '0;
            for (k = 0; k < 5; k++) begin
                d = 8'($urandom_range(0, 255));
                if (zero_sum && k == 4) d = sum;
                c[2*k]     = hex_char(d[7:4]);
                c[2*k + 1] = hex_char(d[3:0]);
                sum ^= d;
            end
        end while (!zero_sum && sum == 8'h00);
        c[CHECK_POS]     = hex_char(sum[7:4]);
        c[CHECK_POS + 1] = hex_char(sum[3:0]);
        n = HEX_CHARS + $urandom_range(0, 2);
        for (k = HEX_CHARS; k < n; k++) c[k] = extra_char();
    endtask

    // fills frame_bytes with one random frame or a burst of noise
    task automatic queue_frame();
        t_chars c;
        int     n;
        int     pick;
        int     k;
        int     p;
        frame_bytes.delete();
        pick = $urandom_range(0, 99);
        if (pick >= 90 && pick < 95) begin
            repeat ($urandom_range(1, 8)) frame_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end
        if (pick < 55 || pick >= 95) begin
            p = $urandom_range(0, POOL_SIZE - 1);
            c = pool_chars[p];
            n = pool_len[p];
        end else begin
            build_chars(pick >= 85, c, n);
        end
        if (pick >= 65 && pick < 75) begin
            if ($urandom_range(0, 1)) c[CHECK_POS + 1] = (c[CHECK_POS + 1] == "0") ? "1" : "0";
            else c[$urandom_range(0, HEX_CHARS - 1)] = 8'($urandom_range(8'h67, 8'h7a));
        end else if (pick >= 75 && pick < 80) begin
            n = $urandom_range(0, HEX_CHARS - 1);
        end else if (pick >= 80 && pick < 85) begin
            // overlong: characters past the buffer are dropped
            n = MAX_CHARS - $urandom_range(0, 5);
            for (k = HEX_CHARS; k < n; k++) c[k] = extra_char();
        end
        if (pick < 95) frame_bytes.push_back(BYTE_START);
        for (k = 0; k < n; k++) frame_bytes.push_back(c[k]);
        frame_bytes.push_back(BYTE_END);
    endtask

    // leaves valid high after the request is taken
    task automatic send_byte(input logic [7:0] b);
        if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
            u_rx_if.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk);
        end
        u_rx_if.valid   <= 1'b1;
        u_rx_if.rx_byte <= b;
        @(posedge clk);
        while (!u_rx_if.ready) @(posedge clk);
        items_sent++;
    endtask

    task automatic send_frame();
        foreach (frame_bytes[k]) send_byte(frame_bytes[k]);
    endtask

    task automatic settle();
        u_rx_if.valid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input t_mode m);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        int    phase;
        int    seg;
        int    k;
        int    seg_start;
        t_mode seg_mode;
        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_wdata        <= MODE_NONE;
        u_rx_if.valid    <= 1'b0;
        u_rx_if.rx_byte  <= 8'h00;
        for (k = 0; k < POOL_SIZE; k++) build_chars(1'b0, pool_chars[k], pool_len[k]);
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // end byte with no start, then on an empty buffer, then a good frame in
        // the reset mode (no action)
        send_byte(8'hff);
        send_byte(8'h00);
        send_byte(BYTE_END);
        send_byte(BYTE_END);
        frame_bytes.delete();
        frame_bytes.push_back(BYTE_START);
        for (k = 0; k < pool_len[0]; k++) frame_bytes.push_back(pool_chars[0][k]);
        frame_bytes.push_back(BYTE_END);
        send_frame();
        settle();

        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            for (seg = 0; seg < SEGMENTS; seg++) begin
                case (seg)
                    0: seg_mode = MODE_REG;
                    1: seg_mode = MODE_DEREG;
                    2: seg_mode = MODE_CHECK;
                    default: seg_mode = (phase == 0) ? MODE_NONE : t_mode'($urandom_range(0, 3));
                endcase
                write_mode(seg_mode);
                seg_start = items_sent;
                while (items_sent - seg_start < SEGMENT_ITEMS) begin
                    queue_frame();
                    send_frame();
                end
                // hold off until every result is back before the next mode write
                settle();
            end
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && results_owed == 0) begin
            $display("rfid_frame_check_and_id_table_core test passed");
        end else begin
            $display("rfid_frame_check_and_id_table_core test failed");
        end
        $finish;
    end

endmodule
